// File: rtl/rpsc_pkg.sv
// rpsc_pkg: shared types and constants of the relay power switch controller
`default_nettype none
package rpsc_pkg;

  localparam int TickW  = 12;
  localparam int BlinkW = 7;
  localparam int IdxW   = 3;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_STARTUP     = 3'd0;
  localparam logic [IdxW-1:0] REG_POLL        = 3'd1;
  localparam logic [IdxW-1:0] REG_BLINK_HALF  = 3'd2;
  localparam logic [IdxW-1:0] REG_OFF_HOLD    = 3'd3;
  localparam logic [IdxW-1:0] REG_RESET_HOLD  = 3'd4;
  localparam logic [IdxW-1:0] REG_SETTLE      = 3'd5;
  localparam logic [IdxW-1:0] REG_FAULT_HALF  = 3'd6;

  // configuration reset values
  localparam logic [TickW-1:0]  StartupDefault    = 12'd500;
  localparam logic [TickW-1:0]  PollDefault       = 12'd100;
  localparam logic [TickW-1:0]  BlinkHalfDefault  = 12'd100;
  localparam logic [BlinkW-1:0] OffHoldDefault    = 7'd10;
  localparam logic [BlinkW-1:0] ResetHoldDefault  = 7'd50;
  localparam logic [TickW-1:0]  SettleDefault     = 12'd1500;
  localparam logic [TickW-1:0]  FaultHalfDefault  = 12'd50;

  typedef enum logic [2:0] {
    PH_STARTUP = 3'd0,
    PH_POLL    = 3'd1,
    PH_HOLD    = 3'd2,
    PH_SETTLE  = 3'd3,
    PH_RELEASE = 3'd4,
    PH_FAULT   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0]  startup_ms;
    logic [TickW-1:0]  poll_ms;
    logic [TickW-1:0]  blink_half_ms;
    logic [BlinkW-1:0] off_hold_blinks;
    logic [BlinkW-1:0] reset_hold_blinks;
    logic [TickW-1:0]  settle_ms;
    logic [TickW-1:0]  fault_half_ms;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TickW-1:0]  tick_count;
    logic [BlinkW-1:0] blinks_left;
    logic              blink_lit;
    logic              hold_is_reset;
    logic              relay_closed;
    logic              settle_done;
    logic              green_state;
    logic              red_state;
  } ctl_state_t;

  typedef struct packed {
    logic relay_drive;
    logic red_lamp;
    logic green_lamp;
    logic fault_latched;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/rpsc_step.sv
// rpsc_step: next-state and result logic for one tick
`default_nettype none
module rpsc_step (
  input  rpsc_pkg::ctl_state_t state,
  input  rpsc_pkg::cfg_t       cfg,
  input  logic                 pw,
  input  logic                 rs,
  input  logic                 ok,
  output rpsc_pkg::ctl_state_t state_next,
  output rpsc_pkg::result_t    res
);
  import rpsc_pkg::*;

  logic [TickW-1:0]  tick_inc;
  logic [TickW-1:0]  limit;
  logic              reached;
  logic              held;
  logic [BlinkW-1:0] blinks_dec;

  // saturating tick counter
  assign tick_inc = (state.tick_count < TickMax) ? state.tick_count + 1'b1 : state.tick_count;

  always_comb begin
    case (state.phase)
      PH_STARTUP: limit = cfg.startup_ms;
      PH_POLL:    limit = cfg.poll_ms;
      PH_HOLD:    limit = cfg.blink_half_ms;
      PH_SETTLE:  limit = cfg.settle_ms;
      PH_FAULT:   limit = cfg.fault_half_ms;
      default:    limit = '0;
    endcase
  end

  assign reached = tick_inc >= limit;
  assign held    = state.hold_is_reset ? rs : pw;

  always_comb begin
    if (state.hold_is_reset && pw) begin
      blinks_dec = '0;
    end else if (state.blinks_left != '0) begin
      blinks_dec = state.blinks_left - 1'b1;
    end else begin
      blinks_dec = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (state.phase != PH_FAULT && state.relay_closed && state.settle_done && !ok) begin
      state_next.phase        = PH_FAULT;
      state_next.relay_closed = 1'b0;
      state_next.green_state  = 1'b0;
      state_next.red_state    = 1'b1;
      state_next.tick_count   = '0;
    end else begin
      case (state.phase)
        PH_STARTUP, PH_POLL: begin
          state_next.tick_count = tick_inc;
          if (reached) begin
            if (rs) begin
              if (state.relay_closed) begin
                state_next.hold_is_reset = 1'b1;
                state_next.blinks_left   = cfg.reset_hold_blinks;
                state_next.blink_lit     = 1'b1;
                state_next.green_state   = 1'b1;
                state_next.tick_count    = '0;
                state_next.phase         = PH_HOLD;
              end else begin
                state_next.green_state = 1'b1;
                state_next.phase       = PH_RELEASE;
              end
            end else if (pw) begin
              if (!state.relay_closed) begin
                state_next.relay_closed = 1'b1;
                state_next.red_state    = 1'b1;
                state_next.settle_done  = 1'b0;
                state_next.green_state  = 1'b1;
                state_next.tick_count   = '0;
                state_next.phase        = PH_SETTLE;
              end else begin
                state_next.hold_is_reset = 1'b0;
                state_next.blinks_left   = cfg.off_hold_blinks;
                state_next.blink_lit     = 1'b1;
                state_next.green_state   = 1'b1;
                state_next.tick_count    = '0;
                state_next.phase         = PH_HOLD;
              end
            end else begin
              state_next.tick_count = '0;
            end
          end
        end
        PH_HOLD: begin
          state_next.tick_count = tick_inc;
          if (reached) begin
            state_next.tick_count = '0;
            if (state.blink_lit) begin
              state_next.blink_lit   = 1'b0;
              state_next.green_state = 1'b0;
            end else begin
              state_next.blinks_left = blinks_dec;
              if (!held) begin
                state_next.phase = PH_RELEASE;
              end else if (blinks_dec == '0) begin
                state_next.relay_closed = 1'b0;
                state_next.red_state    = 1'b0;
                state_next.green_state  = 1'b1;
                state_next.phase        = PH_RELEASE;
              end else begin
                state_next.blink_lit   = 1'b1;
                state_next.green_state = 1'b1;
              end
            end
          end
        end
        PH_SETTLE: begin
          state_next.tick_count = tick_inc;
          if (reached) begin
            state_next.settle_done = 1'b1;
            state_next.phase       = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (pw || rs) begin
            state_next.green_state = 1'b1;
          end else begin
            state_next.green_state = 1'b0;
            state_next.phase       = PH_POLL;
            state_next.tick_count  = '0;
          end
        end
        PH_FAULT: begin
          state_next.tick_count = tick_inc;
          if (reached) begin
            state_next.tick_count = '0;
            state_next.red_state  = !state.red_state;
          end
        end
        default: begin
          state_next.green_state = 1'b0;
          state_next.phase       = PH_POLL;
          state_next.tick_count  = '0;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res.relay_drive   = state_next.relay_closed;
    res.red_lamp      = state_next.red_state;
    res.green_lamp    = state_next.green_state;
    res.fault_latched = (state_next.phase == PH_FAULT);
  end

endmodule
`default_nettype wire

// File: rtl/relay_power_switch_controller_unit.sv
// relay_power_switch_controller_unit: relay controller top level with handshake stages
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    power_button, reset_button, supply_ok
//   out      output     out_valid/out_ready  relay_drive, red_lamp, green_lamp, fault_latched
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one tick per clock cycle sustained unless the output stalls; a tick's result is presented after
// acceptance via the input register, then the result register after the state update
// the whole state update of a tick is a single combinational pass in rpsc_step
// rst clears state and loads the default configuration; cfg_ready is always high
// a stalled result register holds the input register, which then stalls the input
`default_nettype none
module relay_power_switch_controller_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       power_button,
  input  logic                       reset_button,
  input  logic                       supply_ok,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       relay_drive,
  output logic                       red_lamp,
  output logic                       green_lamp,
  output logic                       fault_latched,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rpsc_pkg::IdxW-1:0]  cfg_index,
  input  logic [rpsc_pkg::TickW-1:0] cfg_data
);
  import rpsc_pkg::*;

  cfg_t       cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  result_t    res;
  logic       in_q_valid;
  logic       in_q_pw;
  logic       in_q_rs;
  logic       in_q_ok;
  logic       advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.startup_ms        <= StartupDefault;
      cfg.poll_ms           <= PollDefault;
      cfg.blink_half_ms     <= BlinkHalfDefault;
      cfg.off_hold_blinks   <= OffHoldDefault;
      cfg.reset_hold_blinks <= ResetHoldDefault;
      cfg.settle_ms         <= SettleDefault;
      cfg.fault_half_ms     <= FaultHalfDefault;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STARTUP:    cfg.startup_ms        <= cfg_data;
        REG_POLL:       cfg.poll_ms           <= cfg_data;
        REG_BLINK_HALF: cfg.blink_half_ms     <= cfg_data;
        REG_OFF_HOLD:   cfg.off_hold_blinks   <= cfg_data[BlinkW-1:0];
        REG_RESET_HOLD: cfg.reset_hold_blinks <= cfg_data[BlinkW-1:0];
        REG_SETTLE:     cfg.settle_ms         <= cfg_data;
        REG_FAULT_HALF: cfg.fault_half_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_pw <= power_button;
      in_q_rs <= reset_button;
      in_q_ok <= supply_ok;
    end
  end

  rpsc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .pw         (in_q_pw),
    .rs         (in_q_rs),
    .ok         (in_q_ok),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_STARTUP;
      state.tick_count    <= '0;
      state.blinks_left   <= '0;
      state.blink_lit     <= 1'b0;
      state.hold_is_reset <= 1'b0;
      state.relay_closed  <= 1'b0;
      state.settle_done   <= 1'b0;
      state.green_state   <= 1'b0;
      state.red_state     <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_drive   <= res.relay_drive;
      red_lamp      <= res.red_lamp;
      green_lamp    <= res.green_lamp;
      fault_latched <= res.fault_latched;
    end
  end

`ifndef ASSERT_OFF
  // a latched fault is left only through reset
  a_fault_sticks: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_FAULT |=> state.phase == PH_FAULT)
    else $error("fault phase left without reset");

  // red is always lit while the relay is closed
  a_red_with_relay: assert property (@(posedge clk)
    state.relay_closed |-> state.red_state)
    else $error("relay closed with red lamp off");

  // a delivered fault never comes with the relay driven
  a_fault_relay_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault_latched |-> !relay_drive)
    else $error("relay driven in fault");

  // a held tick in the input register is not dropped
  a_in_held: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid)
    else $error("input register lost a transaction");
`endif

endmodule
`default_nettype wire

// File: verif/relay_power_switch_controller_unit_tb.sv
// testbench for the relay power switch controller: directed and random ticks checked against a predictor
`timescale 1ns / 1ps
module relay_power_switch_controller_unit_tb;
  import rpsc_pkg::*;

  localparam int ClkHalf = 5;
  localparam int HoldOffCycles = 60;
  localparam int StallLimit = 5000;
  localparam int TailCycles = 4;
  localparam logic [IdxW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic    pw;
    logic    rs;
    logic    ok;
    logic    typed;
    result_t lamps;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic power_button = 1'b0;
  logic reset_button = 1'b0;
  logic supply_ok = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic relay_drive;
  logic red_lamp;
  logic green_lamp;
  logic fault_latched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic [TickW-1:0] cfg_data = '0;

  ctl_state_t ctl;
  cfg_t settings;
  result_t expected_lamps [$];
  tick_row_t typed_q [$];
  int ticks_sent = 0;
  int lamps_seen = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int relay_closings = 0;
  int relay_openings = 0;
  int fault_ticks = 0;

  // directed ticks, all limits at one (zero where zero acts as one)
  tick_row_t directed_rows [23] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1, 4'b0000},  // first poll after reset, nothing pressed
    '{1'b0, 1'b1, 1'b1, 1'b1, 4'b0010},  // reset with relay open only lights green
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b1, 1'b0, 1'b1, 1'b0, 4'b0000},  // power press closes relay
    '{1'b1, 1'b0, 1'b0, 1'b0, 4'b0000},  // short ignored while settling
    '{1'b1, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b1, 1'b0, 1'b1, 1'b0, 4'b0000},  // power hold starts
    '{1'b1, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b1, 1'b0, 1'b1, 1'b1, 4'b0010},  // one blink held, relay opens
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b1, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b1, 1'b1, 1'b0, 4'b0000},  // reset hold starts
    '{1'b0, 1'b1, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},  // released early, relay stays closed
    '{1'b0, 1'b0, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b1, 1'b1, 1'b0, 4'b0000},
    '{1'b0, 1'b1, 1'b1, 1'b0, 4'b0000},
    '{1'b1, 1'b1, 1'b1, 1'b0, 4'b0000},  // power during reset hold ends it
    '{1'b1, 1'b1, 1'b0, 1'b0, 4'b0000},
    '{1'b0, 1'b0, 1'b0, 1'b0, 4'b0000}
  };

  relay_power_switch_controller_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .power_button  (power_button),
    .reset_button  (reset_button),
    .supply_ok     (supply_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .relay_drive   (relay_drive),
    .red_lamp      (red_lamp),
    .green_lamp    (green_lamp),
    .fault_latched (fault_latched),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  // ---------------- controller predictor ----------------

  function automatic bit count_tick(input logic [TickW-1:0] limit);
    if (ctl.tick_count != TickMax) ctl.tick_count = ctl.tick_count + 1'b1;
    return ctl.tick_count >= limit;
  endfunction

  function automatic void return_to_poll();
    ctl.green_state = 1'b0;
    ctl.phase = PH_POLL;
    ctl.tick_count = '0;
  endfunction

  function automatic void begin_hold(input logic by_reset, input logic [BlinkW-1:0] blinks);
    ctl.hold_is_reset = by_reset;
    ctl.blinks_left = blinks;
    ctl.blink_lit = 1'b1;
    ctl.green_state = 1'b1;
    ctl.tick_count = '0;
    ctl.phase = PH_HOLD;
  endfunction

  function automatic void poll_choice(input logic pw, input logic rs);
    if (rs) begin
      if (ctl.relay_closed) begin
        begin_hold(1'b1, settings.reset_hold_blinks);
      end else begin
        ctl.green_state = 1'b1;
        ctl.phase = PH_RELEASE;
      end
    end else if (pw) begin
      if (!ctl.relay_closed) begin
        ctl.relay_closed = 1'b1;
        ctl.red_state = 1'b1;
        ctl.settle_done = 1'b0;
        ctl.green_state = 1'b1;
        ctl.tick_count = '0;
        ctl.phase = PH_SETTLE;
      end else begin
        begin_hold(1'b0, settings.off_hold_blinks);
      end
    end else begin
      ctl.tick_count = '0;
    end
  endfunction

  function automatic result_t advance_controller(input logic pw, input logic rs, input logic ok);
    logic held;
    if (ctl.phase != PH_FAULT && ctl.relay_closed && ctl.settle_done && !ok) begin
      ctl.phase = PH_FAULT;
      ctl.relay_closed = 1'b0;
      ctl.green_state = 1'b0;
      ctl.red_state = 1'b1;
      ctl.tick_count = '0;
    end else begin
      case (ctl.phase)
        PH_STARTUP: begin
          if (count_tick(settings.startup_ms)) poll_choice(pw, rs);
        end
        PH_POLL: begin
          if (count_tick(settings.poll_ms)) poll_choice(pw, rs);
        end
        PH_HOLD: begin
          if (count_tick(settings.blink_half_ms)) begin
            ctl.tick_count = '0;
            if (ctl.blink_lit) begin
              ctl.blink_lit = 1'b0;
              ctl.green_state = 1'b0;
            end else begin
              // held button is only looked at when a blink ends
              held = ctl.hold_is_reset ? rs : pw;
              if (ctl.blinks_left != 0) ctl.blinks_left = ctl.blinks_left - 1'b1;
              if (ctl.hold_is_reset && pw) ctl.blinks_left = '0;
              if (!held) begin
                ctl.phase = PH_RELEASE;
              end else if (ctl.blinks_left == 0) begin
                ctl.relay_closed = 1'b0;
                ctl.red_state = 1'b0;
                ctl.green_state = 1'b1;
                ctl.phase = PH_RELEASE;
              end else begin
                ctl.blink_lit = 1'b1;
                ctl.green_state = 1'b1;
              end
            end
          end
        end
        PH_SETTLE: begin
          if (count_tick(settings.settle_ms)) begin
            ctl.settle_done = 1'b1;
            ctl.phase = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (pw || rs) ctl.green_state = 1'b1;
          else return_to_poll();
        end
        PH_FAULT: begin
          if (count_tick(settings.fault_half_ms)) begin
            ctl.tick_count = '0;
            ctl.red_state = ~ctl.red_state;
          end
        end
        default: begin
          return_to_poll();
        end
      endcase
    end
    return {ctl.relay_closed, ctl.red_state, ctl.green_state, ctl.phase == PH_FAULT};
  endfunction

  // ---------------- monitor and scoreboard ----------------

  always @(posedge clk) begin : monitor
    string field_names [4];
    result_t want;
    result_t got;
    result_t prev_want;
    tick_row_t row;
    field_names = '{"fault_latched", "green_lamp", "red_lamp", "relay_drive"};
    if (rst) begin
      ctl = '0;
      ctl.phase = PH_STARTUP;
      settings = '{StartupDefault, PollDefault, BlinkHalfDefault, OffHoldDefault,
                   ResetHoldDefault, SettleDefault, FaultHalfDefault};
      prev_want = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STARTUP:    settings.startup_ms = cfg_data;
          REG_POLL:       settings.poll_ms = cfg_data;
          REG_BLINK_HALF: settings.blink_half_ms = cfg_data;
          REG_OFF_HOLD:   settings.off_hold_blinks = cfg_data[BlinkW-1:0];
          REG_RESET_HOLD: settings.reset_hold_blinks = cfg_data[BlinkW-1:0];
          REG_SETTLE:     settings.settle_ms = cfg_data;
          REG_FAULT_HALF: settings.fault_half_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = advance_controller(power_button, reset_button, supply_ok);
        if (want.relay_drive && !prev_want.relay_drive) relay_closings++;
        if (!want.relay_drive && prev_want.relay_drive && !want.fault_latched) relay_openings++;
        if (want.fault_latched) fault_ticks++;
        prev_want = want;
        if (typed_q.size() != 0) begin
          row = typed_q.pop_front();
          if (row.typed) want = row.lamps;
        end
        expected_lamps.push_back(want);
      end
      if (out_valid && out_ready) begin
        lamps_seen++;
        got = {relay_drive, red_lamp, green_lamp, fault_latched};
        if (expected_lamps.size() == 0) begin
          $display("%0t: result %b arrived with nothing expected", $realtime, got);
          fail_count++;
        end else begin
          want = expected_lamps.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (want[i] !== got[i]) begin
              $display("%0t: %s expected %0b got %0b", $realtime, field_names[i], want[i], got[i]);
              fail_count++;
            end
          end
        end
      end
    end
  end

  // ---------------- receiver ----------------

  always @(posedge clk) begin : receiver
    int hold_left;
    int holds_taken;
    if (rst) begin
      hold_left = 0;
      holds_taken = 0;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_taken != holds_asked) begin
      // long hold-off so the pipeline backs up into the input
      holds_taken++;
      hold_left = HoldOffCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin : watchdog
    int stall_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_tick(input tick_row_t row);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    typed_q.push_back(row);
    in_valid <= 1'b1;
    power_button <= row.pw;
    reset_button <= row.rs;
    supply_ok <= row.ok;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (lamps_seen != ticks_sent) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [IdxW-1:0] idx, input logic [TickW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [TickW-1:0] startup, input logic [TickW-1:0] poll,
                               input logic [TickW-1:0] blink_half, input logic [TickW-1:0] off_hold,
                               input logic [TickW-1:0] reset_hold, input logic [TickW-1:0] settle,
                               input logic [TickW-1:0] fault_half, input bit poke_unused);
    write_register(REG_STARTUP, startup);
    write_register(REG_POLL, poll);
    write_register(REG_BLINK_HALF, blink_half);
    write_register(REG_OFF_HOLD, off_hold);
    write_register(REG_RESET_HOLD, reset_hold);
    write_register(REG_SETTLE, settle);
    write_register(REG_FAULT_HALF, fault_half);
    if (poke_unused) write_register(REG_UNUSED, {TickW{1'b1}});
    cfg_valid <= 1'b0;
  endtask

  // button sequences sized from the current settings so holds run to completion often
  task automatic play_bursts(input int count, input bit shorts);
    int kind;
    int len;
    int poll_len;
    int off_len;
    int rst_len;
    tick_row_t row;
    poll_len = int'(settings.poll_ms) + 1;
    off_len = 2 * int'(settings.blink_half_ms) * (int'(settings.off_hold_blinks) + 1) + poll_len;
    rst_len = 2 * int'(settings.blink_half_ms) * (int'(settings.reset_hold_blinks) + 1) + poll_len;
    while (count > 0) begin
      kind = $urandom_range(5);
      case (kind)
        0: len = $urandom_range(3 * poll_len, 1);
        1: len = $urandom_range(3, 1);
        2: len = $urandom_range(1) ? off_len : $urandom_range(off_len, 1);
        3, 4: len = $urandom_range(1) ? rst_len : $urandom_range(rst_len, 1);
        default: len = $urandom_range(8, 1);
      endcase
      for (int i = 0; i < len && count > 0; i++) begin
        row = '0;
        row.pw = (kind == 1) || (kind == 2) || (kind == 4 && i == len / 2) ||
                 (kind == 5 && $urandom_range(1) == 1);
        row.rs = (kind == 3) || (kind == 4) || (kind == 5 && $urandom_range(1) == 1);
        row.ok = !shorts || ($urandom_range(39) != 0);
        send_tick(row);
        count--;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 87;
    load_settings(0, 1, 1, 1, 1, 0, 1, 1'b0);
    foreach (directed_rows[i]) send_tick(directed_rows[i]);
    wait_quiet();

    load_settings(TickW'($urandom_range(3)), TickW'($urandom_range(3, 1)),
                  TickW'($urandom_range(3, 1)), TickW'($urandom_range(4, 1)),
                  TickW'($urandom_range(4, 1)), TickW'($urandom_range(4)),
                  TickW'($urandom_range(3, 1)), 1'b0);
    play_bursts(100, 1'b0);
    holds_asked++;
    play_bursts(100, 1'b0);
    wait_quiet();

    send_idle_pct = 87;
    recv_idle_pct = 21;
    // zero blink counts act as one
    load_settings(0, 1, 1, 0, 0, 0, 1, 1'b1);
    play_bursts(100, 1'b0);
    wait_quiet();

    load_settings(0, 1, 1, 100, 100, 1, 1, 1'b0);
    play_bursts(150, 1'b0);
    wait_quiet();
    play_bursts(150, 1'b0);
    wait_quiet();

    // top-end limits: settling outlasts this stretch
    load_settings(0, 2, 2, 100, 100, 4095, 4095, 1'b0);
    play_bursts(100, 1'b0);
    wait_quiet();

    // shorts only from here on: a latched fault holds until reset
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(TickW'($urandom_range(3)), TickW'($urandom_range(3, 1)),
                  TickW'($urandom_range(2, 1)), TickW'($urandom_range(3, 1)),
                  TickW'($urandom_range(3, 1)), TickW'($urandom_range(3)),
                  TickW'($urandom_range(3, 1)), 1'b0);
    play_bursts(100, 1'b1);
    holds_asked++;
    play_bursts(100, 1'b1);
    wait_quiet();

    $display("ran %0d ticks over six register settings, limits from zero up to 4095 and 100 blinks",
             ticks_sent);
    $display("relay closed %0d and opened %0d times by buttons, %0d ticks in latched fault",
             relay_closings, relay_openings, fault_ticks);
    if (fail_count == 0 && expected_lamps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rpsc_pkg.sv
rtl/rpsc_step.sv
rtl/relay_power_switch_controller_unit.sv
verif/relay_power_switch_controller_unit_tb.sv
